// ===== rtl/rlkd_pkg.sv =====
// Package for the gimbal rate loop with a Kalman-filtered derivative.
// Holds field widths, register reset values, register indexes and the control struct.
// No dependencies.
package rlkd_pkg;

    // Field and state widths.
    localparam int RATE_W  = 13;
    localparam int ERR_W   = 14;
    localparam int GAIN_W  = 16;
    localparam int NOISE_W = 32;
    localparam int LIM_W   = 12;
    localparam int EST_W   = 32;
    localparam int KG_W    = 25;

    // Iteration counts of the serial units.
    localparam int DIV_STEPS = 25;
    localparam int MUL_STEPS = 32;
    localparam int DRV_STEPS = 16;

    // Measurement unwrapping.
    localparam logic signed [ERR_W-1:0] UNWRAP_ABOVE = 14'sd2000;
    localparam logic signed [ERR_W-1:0] UNWRAP_STEP  = 14'sd4000;

    // Reset values of the configuration registers and the filter state.
    localparam logic [GAIN_W-1:0]  KP_RESET   = 16'd96;
    localparam logic [GAIN_W-1:0]  KI_RESET   = 16'd0;
    localparam logic [GAIN_W-1:0]  KD_RESET   = 16'd1600;
    localparam logic [NOISE_W-1:0] Q_RESET    = 32'd206360;
    localparam logic [NOISE_W-1:0] R_RESET    = 32'd280877315;
    localparam logic [LIM_W-1:0]   ILIM_RESET = 12'd3000;
    localparam logic [LIM_W-1:0]   OLIM_RESET = 12'd3500;
    localparam logic [EST_W-1:0]   EST_RESET  = 32'd65536;
    localparam logic [EST_W-1:0]   COV_RESET  = 32'd503316480;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_KP   = 3'd0;
    localparam logic [2:0] REG_KI   = 3'd1;
    localparam logic [2:0] REG_KD   = 3'd2;
    localparam logic [2:0] REG_Q    = 3'd3;
    localparam logic [2:0] REG_R    = 3'd4;
    localparam logic [2:0] REG_ILIM = 3'd5;
    localparam logic [2:0] REG_OLIM = 3'd6;

    // Start pulses from the sequencer to the serial units.
    typedef struct packed {
        logic div_start;
        logic mul_start;
        logic drv_start;
    } t_ctl;

endpackage

// ===== rtl/rate_loop_kalman_derivative_unit.sv =====
// Top level of the gimbal rate loop: PID drive with a Kalman-filtered derivative.
// Uses rlkd_pkg, rlkd_div, rlkd_mul and rlkd_drive.
//
//   channel  | direction | handshake        | contents
//   s_axis   | in        | tvalid / tready  | tdata[12:0] measured_rate, [25:13] target_rate
//   m_axis   | out       | tvalid / tready  | tdata[12:0] drive_current; tuser output_saturated
//   apb      | in        | psel / penable   | seven registers at byte address 4*i
//
// One request is in work at a time; the next request can be accepted once the previous
// result has been loaded into the output register.
// Each request passes through the 25-step gain divider, the 32-step Kalman multiplier and the
// 16-step gain accumulator, each advancing one bit per cycle.
// Reset is synchronous and active low and restores registers and filter state.
// A new request is accepted while the previous result waits on a stalled output.
module rate_loop_kalman_derivative_unit import rlkd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [12:0] measured_rate, [25:13] target_rate
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [12:0] drive_current
    output logic        o_m_axis_tuser,   // [0] output_saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DRV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // Configuration registers.
    logic [GAIN_W-1:0]  r_kp, r_ki, r_kd;
    logic [NOISE_W-1:0] r_q, r_r;
    logic [LIM_W-1:0]   r_ilim, r_olim;

    // Loop state.
    logic signed [RATE_W-1:0] r_integ, r_prev;
    logic signed [EST_W-1:0]  r_fc;
    logic [31:0]              r_cov;

    // Per-request working values.
    logic [2:0]               r_state;
    logic [2:0]               n_state;
    t_ctl                     r_ctl;
    t_ctl                     n_ctl;
    logic signed [RATE_W-1:0] r_m_in, r_t_in;
    logic signed [ERR_W-1:0]  r_e, r_d;
    logic [31:0]              r_p;
    logic                     r_ovalid;
    logic signed [RATE_W-1:0] r_odrive;
    logic                     r_osat;

    logic signed [ERR_W-1:0]  m_x, m_u, e_c, d_c;
    logic signed [14:0]       isum, ilim_s;
    logic signed [RATE_W-1:0] integ_c;
    logic [32:0]              psum;
    logic [31:0]              p_c;
    logic                     s_acc, cfg_wr, out_load;

    logic                     div_done, mul_done, drv_done;
    logic [KG_W-1:0]          k;
    logic signed [EST_W-1:0]  x;
    logic [31:0]              cov;
    logic signed [RATE_W-1:0] drive;
    logic                     sat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_m_axis_tready);

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= KP_RESET;
            r_ki   <= KI_RESET;
            r_kd   <= KD_RESET;
            r_q    <= Q_RESET;
            r_r    <= R_RESET;
            r_ilim <= ILIM_RESET;
            r_olim <= OLIM_RESET;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_KP:   r_kp   <= pwdata[GAIN_W-1:0];
                REG_KI:   r_ki   <= pwdata[GAIN_W-1:0];
                REG_KD:   r_kd   <= pwdata[GAIN_W-1:0];
                REG_Q:    r_q    <= pwdata;
                REG_R:    r_r    <= pwdata;
                REG_ILIM: r_ilim <= pwdata[LIM_W-1:0];
                REG_OLIM: r_olim <= pwdata[LIM_W-1:0];
                default:  ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (paddr[4:2])
            REG_KP:   prdata = 32'(r_kp);
            REG_KI:   prdata = 32'(r_ki);
            REG_KD:   prdata = 32'(r_kd);
            REG_Q:    prdata = r_q;
            REG_R:    prdata = r_r;
            REG_ILIM: prdata = 32'(r_ilim);
            REG_OLIM: prdata = 32'(r_olim);
            default:  prdata = 32'd0;
        endcase
    end

    // Unwrap, error, clamped integral, rate change and predicted covariance.
    always_comb begin
        m_x    = 14'(r_m_in);
        m_u    = (m_x > UNWRAP_ABOVE) ? m_x - UNWRAP_STEP : m_x;
        e_c    = 14'(r_t_in) - m_u;
        d_c    = m_u - 14'(r_prev);
        isum   = 15'(r_integ) + 15'(e_c);
        ilim_s = signed'(15'(r_ilim));
        if (isum > ilim_s) begin
            integ_c = 13'(ilim_s);
        end else if (isum < -ilim_s) begin
            integ_c = 13'(-ilim_s);
        end else begin
            integ_c = 13'(isum);
        end
        psum = {1'b0, r_cov} + {1'b0, r_q};
        p_c  = psum[32] ? 32'hFFFFFFFF : psum[31:0];
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_ctl   = '0;
        case (r_state)
            S_IDLE: if (s_acc) n_state = S_PREP;
            S_PREP: begin
                n_ctl.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: if (div_done) begin
                n_ctl.mul_start = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: if (mul_done) begin
                n_ctl.drv_start = 1'b1;
                n_state = S_DRV;
            end
            S_DRV: if (drv_done) n_state = S_OUT;
            S_OUT: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ctl    <= '0;
            r_ovalid <= 1'b0;
            r_integ  <= '0;
            r_prev   <= '0;
            r_fc     <= EST_RESET;
            r_cov    <= COV_RESET;
        end else begin
            r_state <= n_state;
            r_ctl   <= n_ctl;
            if (s_acc) begin
                r_m_in <= i_s_axis_tdata[RATE_W-1:0];
                r_t_in <= i_s_axis_tdata[2*RATE_W-1:RATE_W];
            end
            if (r_state == S_PREP) begin
                r_e     <= e_c;
                r_d     <= d_c;
                r_p     <= p_c;
                r_integ <= integ_c;
                r_prev  <= 13'(m_u);
            end
            if (r_state == S_MUL && mul_done) begin
                r_fc  <= x;
                r_cov <= cov;
            end
            // Output register: loads when empty or being drained.
            if (out_load) begin
                r_ovalid <= 1'b1;
                r_odrive <= drive;
                r_osat   <= sat;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    rlkd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_ctl.div_start),
        .i_p     (r_p),
        .i_r     (r_r),
        .o_done  (div_done),
        .o_k     (k)
    );

    rlkd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_ctl.mul_start),
        .i_k     (k),
        .i_p     (r_p),
        .i_d     (r_d),
        .i_fc    (r_fc),
        .o_done  (mul_done),
        .o_x     (x),
        .o_cov   (cov)
    );

    rlkd_drive u_drive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_ctl.drv_start),
        .i_kp    (r_kp),
        .i_ki    (r_ki),
        .i_kd    (r_kd),
        .i_e     (r_e),
        .i_integ (r_integ),
        .i_x     (r_fc),
        .i_olim  (r_olim),
        .o_done  (drv_done),
        .o_drive (drive),
        .o_sat   (sat)
    );

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {3'd0, r_odrive};
    assign o_m_axis_tuser  = r_osat;

endmodule

// ===== rtl/rlkd_div.sv =====
// Bit-serial restoring divider for the Kalman gain K = p * 2^24 / (p + r).
// One quotient bit per cycle. Depends on rlkd_pkg.
module rlkd_div import rlkd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_p,
    input  logic [31:0]       i_r,
    output logic              o_done,
    output logic [KG_W-1:0]   o_k
);

    logic            r_busy;
    logic            r_done;
    logic [4:0]      r_cnt;
    logic [32:0]     r_rem;
    logic [32:0]     r_den;
    logic [KG_W-1:0] r_q;
    logic            r_zero;
    logic [33:0]     trial;

    // The first step decides the integer bit, the later ones shift the remainder.
    assign trial = (r_cnt == 5'd0) ? {1'b0, r_rem} : {r_rem, 1'b0};

    // Compare and subtract one bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= {1'b0, i_p};
                r_den  <= {1'b0, i_p} + {1'b0, i_r};
                r_zero <= (i_p == 32'd0) && (i_r == 32'd0);
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_den}) begin
                    r_rem <= 33'(trial - {1'b0, r_den});
                    r_q   <= {r_q[KG_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial[32:0];
                    r_q   <= {r_q[KG_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // A zero denominator gives a zero gain.
    assign o_k    = r_zero ? '0 : r_q;
    assign o_done = r_done;

endmodule

// ===== rtl/rlkd_mul.sv =====
// Bit-serial multipliers for the Kalman estimate and covariance updates.
// Both products advance one multiplier bit per cycle. Depends on rlkd_pkg.
module rlkd_mul import rlkd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [KG_W-1:0]         i_k,
    input  logic [31:0]             i_p,
    input  logic signed [ERR_W-1:0] i_d,
    input  logic signed [EST_W-1:0] i_fc,
    output logic                    o_done,
    output logic signed [EST_W-1:0] o_x,
    output logic [31:0]             o_cov
);

    localparam logic signed [35:0] X_MAX = 36'sd2147483647;
    localparam logic signed [35:0] X_MIN = -36'sd2147483648;

    logic                    r_busy;
    logic                    r_done;
    logic [4:0]              r_cnt;
    logic [31:0]             r_ksh;
    logic [31:0]             r_psh;
    logic [KG_W-1:0]         r_omk;
    logic signed [33:0]      r_diff;
    logic signed [EST_W-1:0] r_fc;
    logic signed [58:0]      r_accx;
    logic [56:0]             r_accc;
    logic signed [35:0]      xs;

    // MSB-first shift and add over K for the estimate and over p for the covariance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ksh  <= {7'd0, i_k};
                r_psh  <= i_p;
                r_omk  <= 25'h1000000 - i_k;
                r_diff <= (34'(i_d) <<< 16) - 34'(i_fc);
                r_fc   <= i_fc;
                r_accx <= '0;
                r_accc <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_accx <= (r_accx <<< 1) + (r_ksh[31] ? 59'(r_diff) : 59'sd0);
                r_accc <= (r_accc << 1) + (r_psh[31] ? 57'(r_omk) : 57'd0);
                r_ksh  <= {r_ksh[30:0], 1'b0};
                r_psh  <= {r_psh[30:0], 1'b0};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // New estimate with a floor shift of the correction, held to 32 bits.
    always_comb begin
        xs = 36'(r_fc) + 36'(r_accx >>> 24);
        if (xs > X_MAX) begin
            o_x = X_MAX[31:0];
        end else if (xs < X_MIN) begin
            o_x = X_MIN[31:0];
        end else begin
            o_x = xs[31:0];
        end
    end

    assign o_cov  = r_accc[55:24];
    assign o_done = r_done;

endmodule

// ===== rtl/rlkd_drive.sv =====
// Bit-serial gain accumulator for the drive, with truncation and output clamp.
// One bit of each gain per cycle, then a final step to scale and clamp. Depends on rlkd_pkg.
module rlkd_drive import rlkd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [GAIN_W-1:0]        i_kp,
    input  logic [GAIN_W-1:0]        i_ki,
    input  logic [GAIN_W-1:0]        i_kd,
    input  logic signed [ERR_W-1:0]  i_e,
    input  logic signed [RATE_W-1:0] i_integ,
    input  logic signed [EST_W-1:0]  i_x,
    input  logic [LIM_W-1:0]         i_olim,
    output logic                     o_done,
    output logic signed [RATE_W-1:0] o_drive,
    output logic                     o_sat
);

    logic                     r_busy;
    logic                     r_fin;
    logic                     r_done;
    logic [3:0]               r_cnt;
    logic [GAIN_W-1:0]        r_kp;
    logic [GAIN_W-1:0]        r_ki;
    logic [GAIN_W-1:0]        r_kd;
    logic signed [ERR_W-1:0]  r_e;
    logic signed [RATE_W-1:0] r_i;
    logic signed [EST_W-1:0]  r_x;
    logic [LIM_W-1:0]         r_lim;
    logic signed [49:0]       r_acc;
    logic signed [RATE_W-1:0] r_drive;
    logic                     r_sat;
    logic signed [14:0]       pe;
    logic signed [49:0]       term;
    logic signed [49:0]       rnd;
    logic signed [49:0]       v;
    logic signed [49:0]       lim_s;

    // Partial terms for the current gain bit.
    always_comb begin
        pe    = (r_kp[GAIN_W-1] ? 15'(r_e) : 15'sd0)
              + (r_ki[GAIN_W-1] ? 15'(r_i) : 15'sd0);
        term  = (50'(pe) <<< 16) + (r_kd[GAIN_W-1] ? 50'(r_x) : 50'sd0);
        rnd   = r_acc + (r_acc[49] ? 50'sd1048575 : 50'sd0);
        v     = rnd >>> (GAIN_W + 4);
        lim_s = signed'(50'(r_lim));
    end

    // Accumulate, then truncate toward zero and clamp.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_kp   <= i_kp;
                r_ki   <= i_ki;
                r_kd   <= i_kd;
                r_e    <= i_e;
                r_i    <= i_integ;
                r_x    <= i_x;
                r_lim  <= i_olim;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= (r_acc <<< 1) + term;
                r_kp  <= {r_kp[GAIN_W-2:0], 1'b0};
                r_ki  <= {r_ki[GAIN_W-2:0], 1'b0};
                r_kd  <= {r_kd[GAIN_W-2:0], 1'b0};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(DRV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                if (v > lim_s) begin
                    r_drive <= 13'(lim_s);
                    r_sat   <= 1'b1;
                end else if (v < -lim_s) begin
                    r_drive <= 13'(-lim_s);
                    r_sat   <= 1'b1;
                end else begin
                    r_drive <= 13'(v);
                    r_sat   <= 1'b0;
                end
                r_done <= 1'b1;
            end
        end
    end

    assign o_drive = r_drive;
    assign o_sat   = r_sat;
    assign o_done  = r_done;

endmodule

// ===== rtl/rlkd_checker.sv =====
// Port-level checker for the rate loop top level, attached by a bind statement.
// Depends on rate_loop_kalman_derivative_unit.
module rlkd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // The drive is symmetric and the padding bits stay clear.
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[15:13] == 3'd0 &&
        o_m_axis_tdata[12:0] != 13'h1000)
        else $error("drive out of range");

    // One request at a time, and no result right after acceptance.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready && !$rose(o_m_axis_tvalid))
        else $error("request overlap");

endmodule

bind rate_loop_kalman_derivative_unit rlkd_checker u_rlkd_checker (.*);
